@@ src/unix_time_to_calendar_dst_defines.svh @@
// Assertion macros shared by the calendar converter RTL
`ifndef UNIX_TIME_TO_CALENDAR_DST_DEFINES_SVH
`define UNIX_TIME_TO_CALENDAR_DST_DEFINES_SVH

// Check a condition at every clock edge outside reset
`define UCD_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition is followed by another in the next cycle
`define UCD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/ucd_pkg.sv @@
// Constants, types and calendar helpers for the calendar converter
package ucd_pkg;

    // Reciprocal multipliers for constant division, with their shifts
    localparam logic [31:0] M60_A = 32'd2290649225;  // t / 60, shift 37
    localparam logic [26:0] M60_B = 27'd71582789;    // q / 60, shift 32
    localparam logic [21:0] M24   = 22'd2796203;     // q / 24, shift 26
    localparam logic [19:0] M1461 = 20'd734937;      // e / 1461, shift 30
    localparam logic [16:0] M7    = 17'd74899;       // d / 7, shift 19

    // Day count of 1 March 2100, the first day after the skipped leap day
    localparam logic [15:0] DAY_MAR_2100 = 16'd47541;
    localparam logic [15:0] DAYS_1969    = 16'd365;
    localparam logic [7:0]  YEAR_BASE    = 8'd69;
    localparam logic [7:0]  YEAR_2100    = 8'd200;

    // Register indexes
    localparam logic CFG_STD = 1'b0;
    localparam logic CFG_SUM = 1'b1;

    // Month codes, January is one
    localparam logic [3:0] MON_JAN = 4'd1;
    localparam logic [3:0] MON_FEB = 4'd2;
    localparam logic [3:0] MON_MAR = 4'd3;
    localparam logic [3:0] MON_APR = 4'd4;
    localparam logic [3:0] MON_JUN = 4'd6;
    localparam logic [3:0] MON_SEP = 4'd9;
    localparam logic [3:0] MON_OCT = 4'd10;
    localparam logic [3:0] MON_NOV = 4'd11;
    localparam logic [3:0] MON_DEC = 4'd12;

    typedef struct packed {
        logic [3:0] mon;
        logic [4:0] dom;
        logic [7:0] yr;
        logic [2:0] dow;
        logic [8:0] doy;
        logic       leap;
    } date_t;

    // Length of a month
    function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
        logic [4:0] len;
        begin
            case (m)
                MON_FEB: len = leap ? 5'd29 : 5'd28;
                MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
                default: len = 5'd31;
            endcase
            return len;
        end
    endfunction

    // Day of year of the first day of a month
    function automatic logic [8:0] month_start(input logic leap, input logic [3:0] m);
        logic [8:0] s;
        begin
            case (m)
                4'd1:    s = 9'd0;
                4'd2:    s = 9'd31;
                4'd3:    s = 9'd59;
                4'd4:    s = 9'd90;
                4'd5:    s = 9'd120;
                4'd6:    s = 9'd151;
                4'd7:    s = 9'd181;
                4'd8:    s = 9'd212;
                4'd9:    s = 9'd243;
                4'd10:   s = 9'd273;
                4'd11:   s = 9'd304;
                4'd12:   s = 9'd334;
                default: s = 9'd0;
            endcase
            if (leap && m >= MON_MAR)
            begin
                s = s + 9'd1;
            end
            return s;
        end
    endfunction

    // Remainder by seven of a small value
    function automatic logic [2:0] mod7_small(input logic [5:0] x);
        logic [5:0] v;
        begin
            v = x;
            if (v >= 6'd28) v = v - 6'd28;
            if (v >= 6'd14) v = v - 6'd14;
            if (v >= 6'd7)  v = v - 6'd7;
            return v[2:0];
        end
    endfunction

endpackage

@@ src/ucd_carry.sv @@
// Hour wrap with a one-day carry forward or back across month and year
module ucd_carry
    import ucd_pkg::*;
(
    input  date_t             d_in,
    input  logic signed [6:0] hour_sum,
    output date_t             d_out,
    output logic [4:0]        hour_out
);

    logic [4:0] cur_len;
    logic [4:0] prev_len;
    logic [7:0] prev_yr;
    logic       prev_leap;

    assign cur_len   = month_len(d_in.leap, d_in.mon);
    assign prev_len  = month_len(d_in.leap, d_in.mon - 4'd1);
    assign prev_yr   = d_in.yr - 8'd1;
    assign prev_leap = (prev_yr[1:0] == 2'd0) && (prev_yr != YEAR_2100);

    // Wrap the hour and step the date by one day when needed
    always_comb
    begin
        d_out    = d_in;
        hour_out = hour_sum[4:0];
        if (hour_sum > 7'sd23)
        begin
            hour_out  = 5'(hour_sum - 7'sd24);
            d_out.dow = (d_in.dow == 3'd6) ? 3'd0 : d_in.dow + 3'd1;
            d_out.dom = d_in.dom + 5'd1;
            d_out.doy = d_in.doy + 9'd1;
            if (d_in.dom >= cur_len)
            begin
                d_out.dom = 5'd1;
                d_out.mon = d_in.mon + 4'd1;
                if (d_in.mon == MON_DEC)
                begin
                    d_out.mon = MON_JAN;
                    d_out.yr  = d_in.yr + 8'd1;
                    d_out.doy = 9'd0;
                end
            end
        end
        else if (hour_sum < 7'sd0)
        begin
            hour_out  = 5'(hour_sum + 7'sd24);
            d_out.dow = (d_in.dow == 3'd0) ? 3'd6 : d_in.dow - 3'd1;
            d_out.dom = d_in.dom - 5'd1;
            d_out.doy = d_in.doy - 9'd1;
            if (d_in.dom == 5'd1)
            begin
                if (d_in.mon == MON_JAN)
                begin
                    d_out.mon = MON_DEC;
                    d_out.yr  = prev_yr;
                    d_out.doy = prev_leap ? 9'd365 : 9'd364;
                    d_out.dom = 5'd31;
                end
                else
                begin
                    d_out.mon = d_in.mon - 4'd1;
                    d_out.dom = prev_len;
                end
            end
        end
    end

endmodule

@@ src/unix_time_to_calendar_dst.sv @@
// Top level: pipelined epoch seconds to calendar date with summer time
//
//  channel | direction | handshake              | payload
//  in      | input     | in_valid / in_ready    | epoch_seconds, local_mode
//  out     | output    | out_valid / out_ready  | seconds .. summer_time
//  cfg     | input     | cfg_we                 | cfg_index, cfg_wdata
//
// Nine register stages; one beat enters per cycle unless the output stalls,
// and its result is valid once it has passed through all nine.
// The division chain (by 60, 60, 24, 1461 and 7) sets the stage count.
// A stall at the output freezes every stage together; no beat is lost.
// Reset clears the valid bits and loads offsets 0 (standard) and 1 (summer).
module unix_time_to_calendar_dst
    import ucd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] epoch_seconds,
    input  logic        local_mode,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  seconds,
    output logic [5:0]  minutes,
    output logic [4:0]  hours,
    output logic [4:0]  day_of_month,
    output logic [3:0]  month_index,
    output logic [7:0]  year_since_1900,
    output logic [2:0]  weekday,
    output logic [8:0]  day_of_year,
    output logic        summer_time,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [4:0]  cfg_wdata
);

`include "unix_time_to_calendar_dst_defines.svh"

    logic       en;
    logic [9:1] v_reg;

    logic [4:0] std_off_reg;
    logic [4:0] sum_off_reg;

    // Stage registers
    logic [31:0] t1_reg;
    logic [63:0] p1_reg;
    logic [26:0] q1_2_reg;
    logic [52:0] p2_reg;
    logic [20:0] q2_3_reg;
    logic [42:0] p3_reg;
    logic [15:0] e4_reg;
    logic [15:0] dw4_reg;
    logic [35:0] p4_reg;
    logic [32:0] p7_reg;
    logic [5:0]  q4_5_reg;
    logic [10:0] r5_reg;
    logic [2:0]  dow5_reg;
    logic [8:0]  doyf6_reg;
    logic [7:0]  yr6_reg;
    logic        leapf6_reg;
    logic [2:0]  dow6_reg;
    date_t       d7_reg;
    date_t       d8_reg;
    logic signed [6:0] hs8_reg;
    logic        dst8_reg;

    logic [5:0]  sec_reg [2:8];
    logic [5:0]  min_reg [3:8];
    logic [4:0]  hr_reg  [4:7];
    logic        loc_reg [1:7];

    logic [5:0]  sec_out_reg;
    logic [5:0]  min_out_reg;
    logic [4:0]  hr_out_reg;
    date_t       d_out_reg;
    logic        dst_out_reg;

    assign en        = !v_reg[9] || out_ready;
    assign in_ready  = en;
    assign out_valid = v_reg[9];

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            std_off_reg <= 5'd0;
            sum_off_reg <= 5'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_STD: std_off_reg <= cfg_wdata;
                CFG_SUM: sum_off_reg <= cfg_wdata;
                default: std_off_reg <= std_off_reg;
            endcase
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[8:1], in_valid};
        end
    end

    // Stage 1: multiply seconds by reciprocal of 60
    logic [63:0] p1_next;
    assign p1_next = {32'b0, epoch_seconds} * {32'b0, M60_A};

    // Stage 2: seconds, then minutes count over 60
    logic [26:0] q1_next;
    logic [31:0] r1_diff;
    logic [52:0] p2_next;
    assign q1_next = p1_reg[63:37];
    assign r1_diff = t1_reg - {5'b0, q1_next} * 32'd60;
    assign p2_next = {26'b0, q1_next} * {26'b0, M60_B};

    // Stage 3: minutes, then hours count over 24
    logic [20:0] q2_next;
    logic [26:0] r2_diff;
    logic [42:0] p3_next;
    assign q2_next = p2_reg[52:32];
    assign r2_diff = q1_2_reg - {6'b0, q2_next} * 27'd60;
    assign p3_next = {22'b0, q2_next} * {21'b0, M24};

    // Stage 4: hour, day count, four-year cycle and weekday products
    logic [15:0] days;
    logic [20:0] r3_diff;
    logic [15:0] e_next;
    logic [15:0] dw_next;
    logic [35:0] p4_next;
    logic [32:0] p7_next;
    assign days    = p3_reg[41:26];
    assign r3_diff = q2_3_reg - {5'b0, days} * 21'd24;
    assign e_next  = days + 16'(days >= DAY_MAR_2100) + DAYS_1969;
    assign dw_next = days + 16'd4;
    assign p4_next = {20'b0, e_next} * {16'b0, M1461};
    assign p7_next = {17'b0, dw_next} * {16'b0, M7};

    // Stage 5: cycle number, day within cycle, weekday
    logic [5:0]  q4_next;
    logic [15:0] r4_diff;
    logic [15:0] dw_diff;
    assign q4_next = p4_reg[35:30];
    assign r4_diff = e4_reg - {10'b0, q4_next} * 16'd1461;
    assign dw_diff = dw4_reg - {2'b0, p7_reg[32:19]} * 16'd7;

    // Stage 6: year within the cycle
    logic [1:0]  yi;
    logic [10:0] doyf_full;
    always_comb
    begin
        if (r5_reg >= 11'd1095)     yi = 2'd3;
        else if (r5_reg >= 11'd730) yi = 2'd2;
        else if (r5_reg >= 11'd365) yi = 2'd1;
        else                        yi = 2'd0;
    end
    assign doyf_full = r5_reg - {9'b0, yi} * 11'd365;

    // Stage 7: month and day from the day of year
    date_t d7_next;
    always_comb
    begin
        d7_next.mon = MON_JAN;
        for (int k = 2; k <= 12; k++)
        begin
            if (doyf6_reg >= month_start(leapf6_reg, 4'(k)))
            begin
                d7_next.mon = 4'(k);
            end
        end
        d7_next.dom  = 5'(doyf6_reg - month_start(leapf6_reg, d7_next.mon) + 9'd1);
        d7_next.yr   = yr6_reg;
        d7_next.dow  = dow6_reg;
        d7_next.leap = leapf6_reg && (yr6_reg != YEAR_2100);
        // Drop the leap day that 2100 does not have
        d7_next.doy  = ((yr6_reg == YEAR_2100) && (doyf6_reg >= 9'd60)) ?
                       doyf6_reg - 9'd1 : doyf6_reg;
    end

    // Stage 8: summer-time rule and offset sum
    logic [2:0] last_dow;
    logic [4:0] last_sun;
    logic       dst_rule;
    logic       dst_next;
    logic [4:0] off_sel;
    logic signed [6:0] hs_next;
    assign last_dow = mod7_small(6'(d7_reg.dow) + 6'd31 - 6'(d7_reg.dom));
    assign last_sun = 5'd31 - 5'(last_dow);
    always_comb
    begin
        if (d7_reg.mon == MON_MAR)
        begin
            if (d7_reg.dom < last_sun)      dst_rule = 1'b0;
            else if (d7_reg.dom > last_sun) dst_rule = 1'b1;
            else                            dst_rule = (hr_reg[7] >= 5'd1);
        end
        else if (d7_reg.mon == MON_OCT)
        begin
            if (d7_reg.dom < last_sun)      dst_rule = 1'b1;
            else if (d7_reg.dom > last_sun) dst_rule = 1'b0;
            else                            dst_rule = (hr_reg[7] < 5'd1);
        end
        else
        begin
            dst_rule = (d7_reg.mon > MON_MAR) && (d7_reg.mon < MON_OCT);
        end
    end
    assign dst_next = loc_reg[7] && dst_rule;
    assign off_sel  = !loc_reg[7] ? 5'd0 : (dst_rule ? sum_off_reg : std_off_reg);
    assign hs_next  = $signed({2'b0, hr_reg[7]}) + $signed({{2{off_sel[4]}}, off_sel});

    // Stage 9: hour wrap and date carry
    date_t      d9_next;
    logic [4:0] hr9_next;
    ucd_carry u_carry (
        .d_in     (d8_reg),
        .hour_sum (hs8_reg),
        .d_out    (d9_next),
        .hour_out (hr9_next)
    );

    // Hold or advance all payload stages together
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg     <= epoch_seconds;
            p1_reg     <= p1_next;
            loc_reg[1] <= local_mode;
            for (int s = 2; s <= 7; s++)
            begin
                loc_reg[s] <= loc_reg[s - 1];
            end

            q1_2_reg   <= q1_next;
            p2_reg     <= p2_next;
            sec_reg[2] <= r1_diff[5:0];
            for (int s = 3; s <= 8; s++)
            begin
                sec_reg[s] <= sec_reg[s - 1];
            end

            q2_3_reg   <= q2_next;
            p3_reg     <= p3_next;
            min_reg[3] <= r2_diff[5:0];
            for (int s = 4; s <= 8; s++)
            begin
                min_reg[s] <= min_reg[s - 1];
            end

            hr_reg[4] <= r3_diff[4:0];
            for (int s = 5; s <= 7; s++)
            begin
                hr_reg[s] <= hr_reg[s - 1];
            end
            e4_reg  <= e_next;
            dw4_reg <= dw_next;
            p4_reg  <= p4_next;
            p7_reg  <= p7_next;

            q4_5_reg <= q4_next;
            r5_reg   <= r4_diff[10:0];
            dow5_reg <= dw_diff[2:0];

            doyf6_reg  <= doyf_full[8:0];
            yr6_reg    <= YEAR_BASE + {q4_5_reg, 2'b0} + {6'b0, yi};
            leapf6_reg <= (yi == 2'd3);
            dow6_reg   <= dow5_reg;

            d7_reg <= d7_next;

            d8_reg   <= d7_reg;
            hs8_reg  <= hs_next;
            dst8_reg <= dst_next;

            sec_out_reg <= sec_reg[8];
            min_out_reg <= min_reg[8];
            hr_out_reg  <= hr9_next;
            d_out_reg   <= d9_next;
            dst_out_reg <= dst8_reg;
        end
    end

    assign seconds         = sec_out_reg;
    assign minutes         = min_out_reg;
    assign hours           = hr_out_reg;
    assign day_of_month    = d_out_reg.dom;
    assign month_index     = d_out_reg.mon - 4'd1;
    assign year_since_1900 = d_out_reg.yr;
    assign weekday         = d_out_reg.dow;
    assign day_of_year     = d_out_reg.doy;
    assign summer_time     = dst_out_reg;

    `UCD_ASSERT_ALWAYS(a_time_range,
        !out_valid || (hours < 5'd24 && minutes < 6'd60 && seconds < 6'd60),
        "time of day out of range")
    `UCD_ASSERT_ALWAYS(a_date_range,
        !out_valid || (day_of_month != 5'd0 && month_index < 4'd12 && day_of_year < 9'd366),
        "date out of range")
    `UCD_ASSERT_ALWAYS(a_summer_months,
        !out_valid || !summer_time || (month_index >= 4'd2 && month_index <= 4'd9),
        "summer time outside March to October")
    `UCD_ASSERT_NEXT(a_valid_moves, v_reg[4] && en, v_reg[5],
        "valid bit lost between stages")

endmodule

@@ tb/unix_time_to_calendar_dst_test.sv @@
// Testbench for the epoch seconds to calendar date converter with summer time
`timescale 1ns / 1ps

module unix_time_to_calendar_dst_test
    import ucd_pkg::*;
();

    typedef struct packed {
        logic [5:0] sec;
        logic [5:0] mins;
        logic [4:0] hr;
        logic [4:0] dom;
        logic [3:0] mon;
        logic [7:0] yr;
        logic [2:0] dow;
        logic [8:0] doy;
        logic       dst;
    } civil_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] epoch_seconds;
    logic        local_mode;
    logic        out_valid;
    logic        out_ready;
    logic [5:0]  seconds;
    logic [5:0]  minutes;
    logic [4:0]  hours;
    logic [4:0]  day_of_month;
    logic [3:0]  month_index;
    logic [7:0]  year_since_1900;
    logic [2:0]  weekday;
    logic [8:0]  day_of_year;
    logic        summer_time;
    logic        cfg_we;
    logic        cfg_index;
    logic [4:0]  cfg_wdata;

    int          std_hours;
    int          dst_hours;
    civil_t      dates_due[$];
    int          errors;
    bit          steady_sink;

    unix_time_to_calendar_dst u_dut (.*);

    always #1 clk = ~clk;

    // Gregorian leap year
    function automatic bit is_leap(input int y);
        return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    endfunction

    // Days in month m (1..12)
    function automatic int days_in(input int y, input int m);
        int d;
        case (m)
            2: d = is_leap(y) ? 29 : 28;
            4, 6, 9, 11: d = 30;
            default: d = 31;
        endcase
        return d;
    endfunction

    // European summer rule on the UTC date and hour
    function automatic bit in_summer(input int y, input int m, input int dom,
                                     input int dow, input int hr);
        int len;
        int last_sun;
        if (m != 3 && m != 10)
            return (m > 3 && m < 10);
        len = days_in(y, m);
        last_sun = len - ((dow + len - dom) % 7);
        if (dom != last_sun)
            return (m == 3) ? (dom > last_sun) : (dom < last_sun);
        return (m == 3) ? (hr >= 1) : (hr < 1);
    endfunction

    // Work out the civil date of one input beat
    function automatic civil_t to_civil(input logic [31:0] t, input bit loc);
        civil_t r;
        int days, yr, dow, mon, doy, dom, hr, ylen;
        bit dst;
        hr = (t / 3600) % 24;
        days = t / 86400;
        yr = 1970;
        dow = 4;
        mon = 1;
        dst = 0;
        forever
        begin
            ylen = is_leap(yr) ? 366 : 365;
            if (days < ylen)
                break;
            dow = (dow + ylen - 364) % 7;
            days -= ylen;
            yr++;
        end
        doy = days;
        dow = (dow + days) % 7;
        while (mon < 12 && days >= days_in(yr, mon))
        begin
            days -= days_in(yr, mon);
            mon++;
        end
        dom = days + 1;
        if (loc)
        begin
            dst = in_summer(yr, mon, dom, dow, hr);
            hr += dst ? dst_hours : std_hours;
            if (hr > 23)
            begin
                hr -= 24;
                dow = (dow + 1) % 7;
                dom++;
                doy++;
                if (dom > days_in(yr, mon))
                begin
                    dom = 1;
                    mon++;
                    if (mon > 12)
                    begin
                        mon = 1;
                        yr++;
                        doy = 0;
                    end
                end
            end
            else if (hr < 0)
            begin
                hr += 24;
                dow = (dow + 6) % 7;
                dom--;
                doy--;
                if (dom < 1)
                begin
                    mon--;
                    if (mon < 1)
                    begin
                        mon = 12;
                        yr--;
                        doy = is_leap(yr) ? 365 : 364;
                    end
                    dom = days_in(yr, mon);
                end
            end
        end
        r.sec = 6'(t % 60);
        r.mins = 6'((t / 60) % 60);
        r.hr = 5'(hr);
        r.dom = 5'(dom);
        r.mon = 4'(mon - 1);
        r.yr = 8'(yr - 1900);
        r.dow = 3'(dow);
        r.doy = 9'(doy);
        r.dst = dst;
        return r;
    endfunction

    // Send one beat, with random idle cycles ahead of it when gaps is set
    task automatic send_time(input logic [31:0] t, input bit loc, input bit gaps);
        while (gaps && $urandom_range(99) < 12)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        epoch_seconds <= t;
        local_mode <= loc;
        dates_due.push_back(to_civil(t, loc));
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Wait until every date has come back, then write an offset pair
    task automatic set_offsets(input logic [4:0] std_v, input logic [4:0] dst_v);
        in_valid <= 1'b0;
        while (dates_due.size() != 0)
            @(posedge clk);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_STD;
        cfg_wdata <= std_v;
        @(posedge clk);
        cfg_index <= CFG_SUM;
        cfg_wdata <= dst_v;
        @(posedge clk);
        cfg_we <= 1'b0;
        std_hours = $signed(std_v);
        dst_hours = $signed(dst_v);
    endtask

    // UTC and local time at epoch edges, around year and summer boundaries
    task automatic test_directed();
        send_time(32'd0, 1'b0, 1'b0);
        send_time(32'hFFFF_FFFF, 1'b0, 1'b0);
        send_time(32'hFFFF_FFFF, 1'b1, 1'b0);
        send_time(32'd951782400, 1'b0, 1'b0);   // 29 Feb 2000
        send_time(32'd4107542400, 1'b0, 1'b0);  // 1 Mar 2100
        set_offsets(5'h10, 5'h0F);              // -16 and +15
        send_time(32'd0, 1'b1, 1'b0);           // back to 1969
        send_time(32'd3600, 1'b1, 1'b0);
        send_time(32'd946684799, 1'b1, 1'b0);   // 31 Dec 1999 late
        send_time(32'd1711846799, 1'b1, 1'b0);  // 31 Mar 2024 00:59:59
        send_time(32'd1711846800, 1'b1, 1'b0);  // 31 Mar 2024 01:00:00
        send_time(32'd1729990799, 1'b1, 1'b0);  // 27 Oct 2024 00:59:59
        send_time(32'd1729990800, 1'b1, 1'b0);
        set_offsets(5'd14, 5'h14);              // +14 and -12
        send_time(32'd946681200, 1'b1, 1'b0);   // 31 Dec 1999 23:00
        send_time(32'd1704067200, 1'b1, 1'b0);  // 1 Jan 2024, stays in 2024
        send_time(32'd1719792000, 1'b1, 1'b0);  // summer, carry back
        send_time(32'd1709251199, 1'b1, 1'b0);
    endtask

    // Random times, mostly local, across several offset settings
    task automatic test_random();
        logic [31:0] t;
        for (int i = 0; i < 700; i++)
        begin
            if (i % 140 == 0)
                set_offsets(5'($urandom), 5'($urandom));
            case ($urandom_range(3))
                0: t = $urandom;
                1: t = 32'd1711846800 + 32'd31556952 * $urandom_range(80)
                       - 32'd400000 + $urandom_range(800000);
                2: t = 32'd1729990800 + 32'd31556952 * $urandom_range(80)
                       - 32'd400000 + $urandom_range(800000);
                default: t = 32'd946684800 + 32'd31556952 * $urandom_range(100)
                       - 32'd90000 + $urandom_range(180000);
            endcase
            steady_sink = (i >= 300 && i < 400);
            send_time(t, $urandom_range(3) != 0, !steady_sink);
        end
        steady_sink = 1'b0;
    endtask

    // Drive the sink's ready
    always @(posedge clk)
        out_ready <= steady_sink || ($urandom_range(99) >= 12);

    // Compare each returned date with the oldest one due
    always @(posedge clk)
    begin
        civil_t got;
        civil_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{seconds, minutes, hours, day_of_month, month_index,
                    year_since_1900, weekday, day_of_year, summer_time};
            if (dates_due.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, actual %p",
                         $realtime, got);
                errors++;
            end
            else
            begin
                want = dates_due.pop_front();
                if (got !== want)
                begin
                    $display("%0t: mismatch, expected %p, actual %p",
                             $realtime, want, got);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        epoch_seconds = '0;
        local_mode = 1'b0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_STD;
        cfg_wdata = '0;
        std_hours = 0;
        dst_hours = 1;
        errors = 0;
        steady_sink = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random();
        in_valid <= 1'b0;
        while (dates_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Hold a hard stop well past the slowest correct run
    initial
    begin
        #500000;
        $display("Verification failed");
        $finish;
    end

endmodule
